/* rtl/core/lcc_pkg.sv */
// shared constants, types and digit helpers for the card number checker
// no dependencies; used by lcc_dabble, lcc_digit_scan and the top level
package lcc_pkg;

    localparam int CARD_W      = 63;
    localparam int DIGITS      = 19;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGITS * DIGIT_W;
    localparam int SHIFT_CNT_W = $clog2(CARD_W);
    localparam int IDX_W       = $clog2(DIGITS);
    localparam int COUNT_W     = 5;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_AMEX    = 2'd1;
    localparam logic [1:0] VERDICT_VISA    = 2'd2;
    localparam logic [1:0] VERDICT_MC      = 2'd3;

    localparam logic [COUNT_W-1:0] LEN_13 = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] LEN_15 = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] LEN_16 = COUNT_W'(16);

    typedef struct packed {
        logic [1:0]         verdict;
        logic               luhn_ok;
        logic [COUNT_W-1:0] digit_count;
    } t_scan_res;

    // shift-add-3 correction of one bcd digit
    function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
        dabble_adjust = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    endfunction

    // doubled digit folded to its digit sum
    function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] dbl;
        dbl = {d, 1'b0};
        if (dbl >= (DIGIT_W+1)'(10)) begin
            dbl = dbl - (DIGIT_W+1)'(9);
        end
        luhn_double = dbl[DIGIT_W-1:0];
    endfunction

    function automatic logic [1:0] brand_of(input logic [DIGIT_W-1:0] hi,
                                            input logic [DIGIT_W-1:0] lo);
        brand_of = VERDICT_INVALID;
        if (hi == DIGIT_W'(3) && (lo == DIGIT_W'(4) || lo == DIGIT_W'(7))) begin
            brand_of = VERDICT_AMEX;
        end else if (hi == DIGIT_W'(4)) begin
            brand_of = VERDICT_VISA;
        end else if (hi == DIGIT_W'(5) && lo >= DIGIT_W'(1) && lo <= DIGIT_W'(5)) begin
            brand_of = VERDICT_MC;
        end
    endfunction

endpackage

/* rtl/core/lcc_dabble.sv */
// bit-serial binary to bcd converter, one input bit per cycle (shift-add-3)
// depends on lcc_pkg
module lcc_dabble (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lcc_pkg::CARD_W-1:0] i_value,
    output logic                      o_done,
    output logic [lcc_pkg::BCD_W-1:0] o_bcd
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [lcc_pkg::SHIFT_CNT_W-1:0]  r_cnt, n_cnt;
    logic [lcc_pkg::CARD_W-1:0]       r_bin, n_bin;
    logic [lcc_pkg::BCD_W-1:0]        r_bcd, n_bcd;
    logic [lcc_pkg::BCD_W-1:0]        adjusted;

    always_comb begin
        for (int i = 0; i < lcc_pkg::DIGITS; i++) begin
            adjusted[i*lcc_pkg::DIGIT_W +: lcc_pkg::DIGIT_W] =
                lcc_pkg::dabble_adjust(r_bcd[i*lcc_pkg::DIGIT_W +: lcc_pkg::DIGIT_W]);
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bin  = i_value;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bin = {r_bin[lcc_pkg::CARD_W-2:0], 1'b0};
            n_bcd = {adjusted[lcc_pkg::BCD_W-2:0], r_bin[lcc_pkg::CARD_W-1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == lcc_pkg::SHIFT_CNT_W'(lcc_pkg::CARD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* rtl/core/lcc_digit_scan.sv */
// walks the bcd digits from the low end, one per cycle: luhn sum mod 10,
// digit count, two leading digits; depends on lcc_pkg
module lcc_digit_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lcc_pkg::BCD_W-1:0]  i_bcd,
    output logic                       o_done,
    output lcc_pkg::t_scan_res         o_res
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [lcc_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic [lcc_pkg::BCD_W-1:0]         r_bcd, n_bcd;
    logic [lcc_pkg::DIGIT_W-1:0]       r_sum, n_sum;
    logic [lcc_pkg::COUNT_W-1:0]       r_count, n_count;
    logic [lcc_pkg::DIGIT_W-1:0]       r_hi, n_hi;
    logic [lcc_pkg::DIGIT_W-1:0]       r_lo, n_lo;
    logic [lcc_pkg::DIGIT_W-1:0]       r_prev, n_prev;
    logic [lcc_pkg::DIGIT_W-1:0]       digit;
    logic [lcc_pkg::DIGIT_W-1:0]       term;
    logic [lcc_pkg::DIGIT_W:0]         sum_wide;
    logic                              len_ok;

    assign digit    = r_bcd[lcc_pkg::DIGIT_W-1:0];
    // odd positions from the low end (0-based) are the doubled ones
    assign term     = r_idx[0] ? lcc_pkg::luhn_double(digit) : digit;
    assign sum_wide = {1'b0, r_sum} + {1'b0, term};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_idx   = r_idx;
        n_bcd   = r_bcd;
        n_sum   = r_sum;
        n_count = r_count;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_prev  = r_prev;
        if (i_start) begin
            n_busy  = 1'b1;
            n_idx   = '0;
            n_bcd   = i_bcd;
            n_sum   = '0;
            n_count = '0;
            n_hi    = '0;
            n_lo    = '0;
            n_prev  = '0;
        end else if (r_busy) begin
            n_bcd  = {{lcc_pkg::DIGIT_W{1'b0}}, r_bcd[lcc_pkg::BCD_W-1:lcc_pkg::DIGIT_W]};
            n_idx  = r_idx + 1'b1;
            n_prev = digit;
            if (sum_wide >= (lcc_pkg::DIGIT_W+1)'(10)) begin
                n_sum = lcc_pkg::DIGIT_W'(sum_wide - (lcc_pkg::DIGIT_W+1)'(10));
            end else begin
                n_sum = sum_wide[lcc_pkg::DIGIT_W-1:0];
            end
            // highest nonzero digit so far sets length and prefix
            if (digit != '0) begin
                n_count = lcc_pkg::COUNT_W'(r_idx) + 1'b1;
                n_hi    = digit;
                n_lo    = r_prev;
            end
            if (r_idx == lcc_pkg::IDX_W'(lcc_pkg::DIGITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_bcd   <= n_bcd;
        r_sum   <= n_sum;
        r_count <= n_count;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_prev  <= n_prev;
    end

    assign len_ok = (r_count == lcc_pkg::LEN_13) || (r_count == lcc_pkg::LEN_15) ||
                    (r_count == lcc_pkg::LEN_16);

    always_comb begin
        o_res.luhn_ok     = (r_sum == '0);
        o_res.digit_count = r_count;
        o_res.verdict     = (o_res.luhn_ok && len_ok) ? lcc_pkg::brand_of(r_hi, r_lo)
                                                      : lcc_pkg::VERDICT_INVALID;
    end

    assign o_done = r_done;

endmodule

/* rtl/core/card_number_luhn_classifier_top.sv */
// Card number checker: takes one 63-bit binary card number per word and returns the brand
// verdict, the Luhn flag and the decimal digit count. One word is worked on at a time and
// passes through the bit-serial binary to bcd shifter (one input bit per cycle), then the
// digit walker (one decimal digit per cycle), then a hold state that hands the result to
// the output register. The next word is accepted as soon as the previous result sits in
// the output register, even while that result waits.
// depends on lcc_pkg, lcc_dabble, lcc_digit_scan
module card_number_luhn_classifier_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lcc_pkg::CARD_W-1:0]    i_card_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_verdict,
    output logic                          o_luhn_ok,
    output logic [lcc_pkg::COUNT_W-1:0]   o_digit_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic                        r_out_valid, n_out_valid;
    lcc_pkg::t_scan_res          r_out, n_out;
    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic                        conv_done;
    logic                        scan_done;
    logic [lcc_pkg::BCD_W-1:0]   bcd;
    lcc_pkg::t_scan_res          scan_res;

    lcc_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (i_card_value),
        .o_done  (conv_done),
        .o_bcd   (bcd)
    );

    lcc_digit_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_done),
        .i_bcd   (bcd),
        .o_done  (scan_done),
        .o_res   (scan_res)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign load_out = (r_state == ST_HOLD) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out       = scan_res;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_verdict     = r_out.verdict;
    assign o_luhn_ok     = r_out.luhn_ok;
    assign o_digit_count = r_out.digit_count;

    a_conv_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> (r_state == ST_CONV))
        else $error("converter finished outside conversion phase");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == ST_SCAN))
        else $error("digit walk finished outside scan phase");

    a_brand_needs_luhn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != lcc_pkg::VERDICT_INVALID) |-> o_luhn_ok)
        else $error("brand reported without luhn pass");

    a_brand_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != lcc_pkg::VERDICT_INVALID) |->
        (o_digit_count == lcc_pkg::LEN_13 || o_digit_count == lcc_pkg::LEN_15 ||
         o_digit_count == lcc_pkg::LEN_16))
        else $error("brand reported with bad length");

endmodule
